// ----- design/lcddcg_pkg.sv -----
// ----------------------------------------------------------------------------
// lcddcg_pkg: shared types and tables of the lcd draw command generator
// Screen and glyph geometry, controller opcodes, the queued job record,
// the 5x8 font and the MADCTL lookup.
// ----------------------------------------------------------------------------
package lcddcg_pkg;

    // geometry
    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 128;
    localparam int GLYPH_WIDTH   = 5;
    localparam int GLYPH_HEIGHT  = 7;

    // coordinate and span widths (a span can reach the full screen size)
    localparam int XW = $clog2(SCREEN_WIDTH + 1);
    localparam int YW = $clog2(SCREEN_HEIGHT + 1);

    localparam int RUN_W  = 15;
    localparam int PROD_W = (XW + YW > RUN_W) ? XW + YW : RUN_W;

    // glyph storage: GLYPH_WIDTH columns of 8 bits each
    localparam int GCOL_W    = 3;
    localparam int GROW_W    = 3;
    localparam int GLYPH_BITS = GLYPH_WIDTH * 8;
    localparam int GLYPH_IDX_W = 7;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // request opcodes
    localparam logic [1:0] OP_FILL = 2'd0;
    localparam logic [1:0] OP_CHAR = 2'd1;
    localparam logic [1:0] OP_ROT  = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_RUN  = 2'd2;

    // controller bytes
    localparam logic [7:0] LCD_CASET  = 8'h2A;
    localparam logic [7:0] LCD_RASET  = 8'h2B;
    localparam logic [7:0] LCD_RAMWR  = 8'h2C;
    localparam logic [7:0] LCD_MADCTL = 8'h36;
    localparam logic [7:0] MAD_ROT1   = 8'h60;
    localparam logic [7:0] MAD_ROT2   = 8'hC0;
    localparam logic [7:0] MAD_ROT3   = 8'hA0;
    localparam logic [7:0] MAD_BGR    = 8'h08;

    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] FINAL_CODE = 8'h7F;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_OFFSET    = 1'b1;

    typedef struct packed {
        logic [1:0]            op;
        logic [15:0]           win_x0;
        logic [15:0]           win_x1;
        logic [15:0]           win_y0;
        logic [15:0]           win_y1;
        logic [15:0]           fg;
        logic [15:0]           bg;
        logic [GLYPH_BITS-1:0] glyph;
        logic [RUN_W-1:0]      run_len;
        logic [7:0]            madctl;
    } job_t;

    function automatic logic [7:0] madctl_byte(input logic [1:0] rot, input logic rgb);
        logic [7:0] b;
        case (rot)
            2'd0:    b = 8'h00;
            2'd1:    b = MAD_ROT1;
            2'd2:    b = MAD_ROT2;
            default: b = MAD_ROT3;
        endcase
        return rgb ? b : (b | MAD_BGR);
    endfunction

    // column 0 in the lowest byte
    function automatic logic [GLYPH_BITS-1:0] g5(input logic [7:0] c0, input logic [7:0] c1,
                                                 input logic [7:0] c2, input logic [7:0] c3,
                                                 input logic [7:0] c4);
        return {c4, c3, c2, c1, c0};
    endfunction

    // font rom, indexed by code minus 0x20
    function automatic logic [GLYPH_BITS-1:0] glyph_cols(input logic [GLYPH_IDX_W-1:0] idx);
        logic [GLYPH_BITS-1:0] g;
        case (idx)
            7'h00: g = g5(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            7'h01: g = g5(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
            7'h02: g = g5(8'h00, 8'h07, 8'h00, 8'h07, 8'h00);
            7'h03: g = g5(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14);
            7'h04: g = g5(8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12);
            7'h05: g = g5(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
            7'h06: g = g5(8'h36, 8'h49, 8'h55, 8'h22, 8'h50);
            7'h07: g = g5(8'h00, 8'h05, 8'h03, 8'h00, 8'h00);
            7'h08: g = g5(8'h00, 8'h1C, 8'h22, 8'h41, 8'h00);
            7'h09: g = g5(8'h00, 8'h41, 8'h22, 8'h1C, 8'h00);
            7'h0A: g = g5(8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08);
            7'h0B: g = g5(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
            7'h0C: g = g5(8'h00, 8'h50, 8'h30, 8'h00, 8'h00);
            7'h0D: g = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
            7'h0E: g = g5(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
            7'h0F: g = g5(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
            7'h10: g = g5(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
            7'h11: g = g5(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
            7'h12: g = g5(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
            7'h13: g = g5(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
            7'h14: g = g5(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
            7'h15: g = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
            7'h16: g = g5(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
            7'h17: g = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
            7'h18: g = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
            7'h19: g = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
            7'h1A: g = g5(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
            7'h1B: g = g5(8'h00, 8'h56, 8'h36, 8'h00, 8'h00);
            7'h1C: g = g5(8'h00, 8'h08, 8'h14, 8'h22, 8'h41);
            7'h1D: g = g5(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
            7'h1E: g = g5(8'h41, 8'h22, 8'h14, 8'h08, 8'h00);
            7'h1F: g = g5(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
            7'h20: g = g5(8'h32, 8'h49, 8'h79, 8'h41, 8'h3E);
            7'h21: g = g5(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
            7'h22: g = g5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            7'h23: g = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            7'h24: g = g5(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
            7'h25: g = g5(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            7'h26: g = g5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
            7'h27: g = g5(8'h3E, 8'h41, 8'h41, 8'h49, 8'h7A);
            7'h28: g = g5(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            7'h29: g = g5(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
            7'h2A: g = g5(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            7'h2B: g = g5(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            7'h2C: g = g5(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            7'h2D: g = g5(8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F);
            7'h2E: g = g5(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            7'h2F: g = g5(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            7'h30: g = g5(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            7'h31: g = g5(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
            7'h32: g = g5(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            7'h33: g = g5(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
            7'h34: g = g5(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            7'h35: g = g5(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            7'h36: g = g5(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
            7'h37: g = g5(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
            7'h38: g = g5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
            7'h39: g = g5(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
            7'h3A: g = g5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
            7'h3B: g = g5(8'h00, 8'h00, 8'h7F, 8'h41, 8'h41);
            7'h3C: g = g5(8'h02, 8'h04, 8'h08, 8'h10, 8'h20);
            7'h3D: g = g5(8'h41, 8'h41, 8'h7F, 8'h00, 8'h00);
            7'h3E: g = g5(8'h04, 8'h02, 8'h01, 8'h02, 8'h04);
            7'h3F: g = g5(8'h40, 8'h40, 8'h40, 8'h40, 8'h40);
            7'h40: g = g5(8'h00, 8'h01, 8'h02, 8'h04, 8'h00);
            7'h41: g = g5(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
            7'h42: g = g5(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
            7'h43: g = g5(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
            7'h44: g = g5(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
            7'h45: g = g5(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
            7'h46: g = g5(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
            7'h47: g = g5(8'h08, 8'h14, 8'h54, 8'h54, 8'h3C);
            7'h48: g = g5(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
            7'h49: g = g5(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
            7'h4A: g = g5(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00);
            7'h4B: g = g5(8'h00, 8'h7F, 8'h10, 8'h28, 8'h44);
            7'h4C: g = g5(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
            7'h4D: g = g5(8'h7C, 8'h04, 8'h18, 8'h04, 8'h78);
            7'h4E: g = g5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
            7'h4F: g = g5(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
            7'h50: g = g5(8'h7C, 8'h14, 8'h14, 8'h14, 8'h08);
            7'h51: g = g5(8'h08, 8'h14, 8'h14, 8'h18, 8'h7C);
            7'h52: g = g5(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
            7'h53: g = g5(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
            7'h54: g = g5(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20);
            7'h55: g = g5(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
            7'h56: g = g5(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
            7'h57: g = g5(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
            7'h58: g = g5(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
            7'h59: g = g5(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C);
            7'h5A: g = g5(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
            7'h5B: g = g5(8'h00, 8'h08, 8'h36, 8'h41, 8'h00);
            7'h5C: g = g5(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);
            7'h5D: g = g5(8'h00, 8'h41, 8'h36, 8'h08, 8'h00);
            7'h5E: g = g5(8'h08, 8'h08, 8'h2A, 8'h1C, 8'h08);
            7'h5F: g = g5(8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ----- design/lcddcg_front.sv -----
// ----------------------------------------------------------------------------
// lcddcg_front: request intake and classification
// Drops requests that draw nothing, clips fills, fetches glyphs, then forms
// the pixel count and offset window addresses of a job for the queue.
// ----------------------------------------------------------------------------
module lcddcg_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // x_pos, y_pos, rect_width, rect_height, char_code, fg_color, bg_color,
    // rotation, rgb_order, zero pad
    input  logic [111:0]       s_axis_tdata,
    // command
    input  logic [1:0]         s_axis_tuser,
    input  logic [15:0]        column_offset,
    input  logic [15:0]        row_offset,
    output logic               push_valid,
    input  logic               push_ready,
    output lcddcg_pkg::job_t   push_job
);

    localparam logic [lcddcg_pkg::XW-1:0] X_MAX = lcddcg_pkg::XW'(lcddcg_pkg::SCREEN_WIDTH - 1);
    localparam logic [lcddcg_pkg::YW-1:0] Y_MAX = lcddcg_pkg::YW'(lcddcg_pkg::SCREEN_HEIGHT - 1);

    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [1:0]  rotation;
    logic        rgb_order;

    logic        accept;
    logic        keep;
    logic        fill_ok;
    logic        char_ok;
    logic [16:0] xe_full;
    logic [16:0] ye_full;
    logic [lcddcg_pkg::XW-1:0] x0_in;
    logic [lcddcg_pkg::XW-1:0] x1_in;
    logic [lcddcg_pkg::YW-1:0] y0_in;
    logic [lcddcg_pkg::YW-1:0] y1_in;

    logic                      s1_valid_reg;
    logic [1:0]                op_reg;
    logic [lcddcg_pkg::XW-1:0] x0_reg;
    logic [lcddcg_pkg::XW-1:0] x1_reg;
    logic [lcddcg_pkg::YW-1:0] y0_reg;
    logic [lcddcg_pkg::YW-1:0] y1_reg;
    logic [15:0]               fg_reg;
    logic [15:0]               bg_reg;
    logic [lcddcg_pkg::GLYPH_BITS-1:0] glyph_reg;
    logic [7:0]                madctl_reg;

    logic [lcddcg_pkg::PROD_W-1:0] span_x;
    logic [lcddcg_pkg::PROD_W-1:0] span_y;
    logic [lcddcg_pkg::PROD_W-1:0] pixels;

    assign x_pos       = s_axis_tdata[15:0];
    assign y_pos       = s_axis_tdata[31:16];
    assign rect_width  = s_axis_tdata[47:32];
    assign rect_height = s_axis_tdata[63:48];
    assign char_code   = s_axis_tdata[71:64];
    assign fg_color    = s_axis_tdata[87:72];
    assign bg_color    = s_axis_tdata[103:88];
    assign rotation    = s_axis_tdata[105:104];
    assign rgb_order   = s_axis_tdata[106];

    assign s_axis_tready = !s1_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // far corner of a fill, without wrap, before clipping
    assign xe_full = {1'b0, x_pos} + {1'b0, rect_width} - 17'd1;
    assign ye_full = {1'b0, y_pos} + {1'b0, rect_height} - 17'd1;

    assign fill_ok = (rect_width != 16'd0) && (rect_height != 16'd0)
                  && ({1'b0, x_pos} < 17'(lcddcg_pkg::SCREEN_WIDTH))
                  && ({1'b0, y_pos} < 17'(lcddcg_pkg::SCREEN_HEIGHT));

    assign char_ok = (char_code >= lcddcg_pkg::FIRST_CODE) && (char_code <= lcddcg_pkg::FINAL_CODE)
                  && ({1'b0, x_pos} + 17'(lcddcg_pkg::GLYPH_WIDTH)
                      <= 17'(lcddcg_pkg::SCREEN_WIDTH))
                  && ({1'b0, y_pos} + 17'(lcddcg_pkg::GLYPH_HEIGHT)
                      <= 17'(lcddcg_pkg::SCREEN_HEIGHT));

    always_comb
    begin
        keep = 1'b0;
        case (s_axis_tuser)
            lcddcg_pkg::OP_FILL: keep = fill_ok;
            lcddcg_pkg::OP_CHAR: keep = char_ok;
            lcddcg_pkg::OP_ROT:  keep = 1'b1;
            default:             keep = 1'b0;
        endcase
    end

    always_comb
    begin
        x0_in = x_pos[lcddcg_pkg::XW-1:0];
        y0_in = y_pos[lcddcg_pkg::YW-1:0];
        if (s_axis_tuser == lcddcg_pkg::OP_CHAR)
        begin
            x1_in = x0_in + lcddcg_pkg::XW'(lcddcg_pkg::GLYPH_WIDTH - 1);
            y1_in = y0_in + lcddcg_pkg::YW'(lcddcg_pkg::GLYPH_HEIGHT - 1);
        end
        else
        begin
            x1_in = (xe_full >= 17'(lcddcg_pkg::SCREEN_WIDTH)) ? X_MAX
                                                                : xe_full[lcddcg_pkg::XW-1:0];
            y1_in = (ye_full >= 17'(lcddcg_pkg::SCREEN_HEIGHT)) ? Y_MAX
                                                                 : ye_full[lcddcg_pkg::YW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= accept && keep;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= s_axis_tuser;
            x0_reg     <= x0_in;
            x1_reg     <= x1_in;
            y0_reg     <= y0_in;
            y1_reg     <= y1_in;
            fg_reg     <= fg_color;
            bg_reg     <= bg_color;
            glyph_reg  <= lcddcg_pkg::glyph_cols(
                              lcddcg_pkg::GLYPH_IDX_W'(char_code - lcddcg_pkg::FIRST_CODE));
            madctl_reg <= lcddcg_pkg::madctl_byte(rotation, rgb_order);
        end
    end

    // pixel count of the clipped rectangle, kept to the run field width
    assign span_x = lcddcg_pkg::PROD_W'(x1_reg - x0_reg) + lcddcg_pkg::PROD_W'(1);
    assign span_y = lcddcg_pkg::PROD_W'(y1_reg - y0_reg) + lcddcg_pkg::PROD_W'(1);
    assign pixels = span_x * span_y;

    assign push_valid       = s1_valid_reg;
    assign push_job.op      = op_reg;
    assign push_job.win_x0  = 16'(x0_reg) + column_offset;
    assign push_job.win_x1  = 16'(x1_reg) + column_offset;
    assign push_job.win_y0  = 16'(y0_reg) + row_offset;
    assign push_job.win_y1  = 16'(y1_reg) + row_offset;
    assign push_job.fg      = fg_reg;
    assign push_job.bg      = bg_reg;
    assign push_job.glyph   = glyph_reg;
    assign push_job.run_len = pixels[lcddcg_pkg::RUN_W-1:0];
    assign push_job.madctl  = madctl_reg;

endmodule

// ----- design/lcddcg_queue.sv -----
// ----------------------------------------------------------------------------
// lcddcg_queue: job queue between front and back
// Small register fifo so that intake and result generation stall apart.
// ----------------------------------------------------------------------------
module lcddcg_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  lcddcg_pkg::job_t push_job,
    output logic             head_valid,
    input  logic             pop,
    output lcddcg_pkg::job_t head_job
);

    lcddcg_pkg::job_t                  entry_reg [lcddcg_pkg::QDEPTH];
    logic [lcddcg_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [lcddcg_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [lcddcg_pkg::QCNT_W-1:0]     count_reg;
    logic [lcddcg_pkg::QCNT_W-1:0]     count_next;
    logic                              do_push;
    logic                              do_pop;

    assign push_ready = (count_reg != lcddcg_pkg::QCNT_W'(lcddcg_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == lcddcg_pkg::QPTR_W'(lcddcg_pkg::QDEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == lcddcg_pkg::QPTR_W'(lcddcg_pkg::QDEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- design/lcddcg_back.sv -----
// ----------------------------------------------------------------------------
// lcddcg_back: result sequencer
// Steps through the window bytes, then the pixel run or the glyph pixels, or for a rotation the
// MADCTL command and byte; one result per cycle unless the output stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module lcddcg_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  lcddcg_pkg::job_t q_job,
    output logic             q_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // value, repeat_res, zero pad
    output logic [31:0]      m_axis_tdata,
    // kind
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int LAST_CHAR = 10 + lcddcg_pkg::GLYPH_WIDTH * lcddcg_pkg::GLYPH_HEIGHT;
    localparam int STEP_W    = $clog2(LAST_CHAR + 1);

    localparam logic [STEP_W-1:0] ST_CASET = STEP_W'(0);
    localparam logic [STEP_W-1:0] ST_X0_HI = STEP_W'(1);
    localparam logic [STEP_W-1:0] ST_X0_LO = STEP_W'(2);
    localparam logic [STEP_W-1:0] ST_X1_HI = STEP_W'(3);
    localparam logic [STEP_W-1:0] ST_X1_LO = STEP_W'(4);
    localparam logic [STEP_W-1:0] ST_RASET = STEP_W'(5);
    localparam logic [STEP_W-1:0] ST_Y0_HI = STEP_W'(6);
    localparam logic [STEP_W-1:0] ST_Y0_LO = STEP_W'(7);
    localparam logic [STEP_W-1:0] ST_Y1_HI = STEP_W'(8);
    localparam logic [STEP_W-1:0] ST_Y1_LO = STEP_W'(9);
    localparam logic [STEP_W-1:0] ST_RAMWR = STEP_W'(10);
    localparam logic [STEP_W-1:0] ST_PIXEL = STEP_W'(11);
    localparam logic [STEP_W-1:0] ST_CHAR_END = STEP_W'(LAST_CHAR);
    localparam logic [STEP_W-1:0] ST_ROT_DATA = STEP_W'(1);

    localparam logic [lcddcg_pkg::GCOL_W-1:0] COL_END =
        lcddcg_pkg::GCOL_W'(lcddcg_pkg::GLYPH_WIDTH - 1);

    lcddcg_pkg::job_t                 job_reg;
    logic                             busy_reg;
    logic [STEP_W-1:0]                step_reg;
    logic [lcddcg_pkg::GCOL_W-1:0]    col_reg;
    logic [lcddcg_pkg::GROW_W-1:0]    row_reg;

    logic                             out_valid_reg;
    logic [1:0]                       out_kind_reg;
    logic [15:0]                      out_value_reg;
    logic [lcddcg_pkg::RUN_W-1:0]     out_rep_reg;
    logic                             out_last_reg;

    logic                             advance;
    logic                             emit;
    logic                             load;
    logic                             pixel_on;
    logic [1:0]                       res_kind;
    logic [15:0]                      res_value;
    logic [lcddcg_pkg::RUN_W-1:0]     res_rep;
    logic                             res_last;

    assign advance  = !out_valid_reg || m_axis_tready;
    assign emit     = busy_reg && advance;
    assign load     = q_valid && (!busy_reg || (emit && res_last));
    assign q_pop    = load;
    assign pixel_on = job_reg.glyph[{col_reg, row_reg}];

    always_comb
    begin
        res_kind  = lcddcg_pkg::KIND_DATA;
        res_value = 16'd0;
        res_rep   = '0;
        res_last  = 1'b0;
        if (job_reg.op == lcddcg_pkg::OP_ROT)
        begin
            if (step_reg == ST_CASET)
            begin
                res_kind  = lcddcg_pkg::KIND_CMD;
                res_value = 16'(lcddcg_pkg::LCD_MADCTL);
            end
            else if (step_reg == ST_ROT_DATA)
            begin
                res_value = 16'(job_reg.madctl);
                res_last  = 1'b1;
            end
        end
        else
        begin
            case (step_reg)
                ST_CASET:
                begin
                    res_kind  = lcddcg_pkg::KIND_CMD;
                    res_value = 16'(lcddcg_pkg::LCD_CASET);
                end
                ST_X0_HI: res_value = 16'(job_reg.win_x0[15:8]);
                ST_X0_LO: res_value = 16'(job_reg.win_x0[7:0]);
                ST_X1_HI: res_value = 16'(job_reg.win_x1[15:8]);
                ST_X1_LO: res_value = 16'(job_reg.win_x1[7:0]);
                ST_RASET:
                begin
                    res_kind  = lcddcg_pkg::KIND_CMD;
                    res_value = 16'(lcddcg_pkg::LCD_RASET);
                end
                ST_Y0_HI: res_value = 16'(job_reg.win_y0[15:8]);
                ST_Y0_LO: res_value = 16'(job_reg.win_y0[7:0]);
                ST_Y1_HI: res_value = 16'(job_reg.win_y1[15:8]);
                ST_Y1_LO: res_value = 16'(job_reg.win_y1[7:0]);
                ST_RAMWR:
                begin
                    res_kind  = lcddcg_pkg::KIND_CMD;
                    res_value = 16'(lcddcg_pkg::LCD_RAMWR);
                end
                default:
                begin
                    res_kind = lcddcg_pkg::KIND_RUN;
                    if (job_reg.op == lcddcg_pkg::OP_FILL)
                    begin
                        res_value = job_reg.fg;
                        res_rep   = job_reg.run_len;
                        res_last  = 1'b1;
                    end
                    else
                    begin
                        res_value = pixel_on ? job_reg.fg : job_reg.bg;
                        res_rep   = lcddcg_pkg::RUN_W'(1);
                        res_last  = (step_reg == ST_CHAR_END);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= busy_reg;
            end
            if (load)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                col_reg  <= '0;
                row_reg  <= '0;
            end
            else if (emit)
            begin
                if (res_last)
                begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 1'b1;
                // glyph pixels go left to right, then down one row
                if (step_reg >= ST_PIXEL)
                begin
                    if (col_reg == COL_END)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= q_job;
        end
        if (emit)
        begin
            out_kind_reg  <= res_kind;
            out_value_reg <= res_value;
            out_rep_reg   <= res_rep;
            out_last_reg  <= res_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_rep_reg, out_value_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- design/lcd_draw_command_generator.sv -----
// ----------------------------------------------------------------------------
// lcd_draw_command_generator: draw requests to panel controller results
// Turns fill, character and rotation requests into command bytes, data
// bytes and pixel colour runs for a small SPI panel controller.
//
//   channel   direction  contents
//   s_axis    in         draw request (tuser = command)
//   m_axis    out        result (tuser = kind, tlast = last of request)
//   cfg       in         column_offset (index 0), row_offset (index 1)
//
// Results leave at one per cycle while m_axis_tready is held: a rotation gives 2, a fill 12, a character
// 11 + 35 = 46 results; the result port and its output register set the rate.
// With the sequencer idle, a request taken at the input passes in order through the
// intake register, job queue, sequencer load and output register before its first result
// shows. New requests are taken while earlier ones are emitted.
// Requests that draw nothing are dropped at intake and give no result.
// Reset clears the offsets, the queue and the sequencer; no clearing pass.
// ----------------------------------------------------------------------------
module lcd_draw_command_generator
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // x_pos, y_pos, rect_width, rect_height, char_code, fg_color, bg_color,
    // rotation, rgb_order, zero pad
    input  logic [111:0]                      s_axis_tdata,
    // command
    input  logic [1:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // value, repeat_res, zero pad
    output logic [31:0]                       m_axis_tdata,
    // kind
    output logic [1:0]                        m_axis_tuser,
    output logic                              m_axis_tlast,
    input  logic                              cfg_we,
    input  logic [lcddcg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                       cfg_data
);

    logic [15:0]      column_offset_reg;
    logic [15:0]      row_offset_reg;

    logic             push_valid;
    logic             push_ready;
    lcddcg_pkg::job_t push_job;
    logic             head_valid;
    logic             pop;
    lcddcg_pkg::job_t head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= 16'd0;
            row_offset_reg    <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lcddcg_pkg::REG_COLUMN_OFFSET: column_offset_reg <= cfg_data;
                lcddcg_pkg::REG_ROW_OFFSET:    row_offset_reg    <= cfg_data;
                default:                       column_offset_reg <= column_offset_reg;
            endcase
        end
    end

    lcddcg_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .column_offset (column_offset_reg),
        .row_offset    (row_offset_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_job      (push_job)
    );

    lcddcg_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .head_valid (head_valid),
        .pop        (pop),
        .head_job   (head_job)
    );

    lcddcg_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (head_valid),
        .q_job         (head_job),
        .q_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ----- dv/tb_lcd_draw_command_generator.sv -----
// ----------------------------------------------------------------------------
// tb_lcd_draw_command_generator: self-checking bench for the draw generator
// Drives fill, character and rotation requests into the stream input and
// checks each output result against a behavioural prediction of the byte,
// data and pixel-run sequence. Both stream sides idle at random, and the
// window offsets are changed between quiet phases.
// ----------------------------------------------------------------------------
module tb_lcd_draw_command_generator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         QUIET_WAIT  = 24;
    localparam int         CYCLE_LIMIT = 4_000_000;
    localparam int         PHASE_DRAWS = 44;

    // 5-column font, five bytes per code from 0x20, bit n is glyph row n
    localparam logic [7:0] FONT_BYTES [0:479] = '{
        8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h5F,8'h00,8'h00,8'h00,8'h07,8'h00,8'h07,8'h00,8'h14,
        8'h7F,8'h14,8'h7F,8'h14,8'h24,8'h2A,8'h7F,8'h2A,8'h12,8'h23,8'h13,8'h08,8'h64,8'h62,8'h36,8'h49,
        8'h55,8'h22,8'h50,8'h00,8'h05,8'h03,8'h00,8'h00,8'h00,8'h1C,8'h22,8'h41,8'h00,8'h00,8'h41,8'h22,
        8'h1C,8'h00,8'h08,8'h2A,8'h1C,8'h2A,8'h08,8'h08,8'h08,8'h3E,8'h08,8'h08,8'h00,8'h50,8'h30,8'h00,
        8'h00,8'h08,8'h08,8'h08,8'h08,8'h08,8'h00,8'h60,8'h60,8'h00,8'h00,8'h20,8'h10,8'h08,8'h04,8'h02,
        8'h3E,8'h51,8'h49,8'h45,8'h3E,8'h00,8'h42,8'h7F,8'h40,8'h00,8'h42,8'h61,8'h51,8'h49,8'h46,8'h21,
        8'h41,8'h45,8'h4B,8'h31,8'h18,8'h14,8'h12,8'h7F,8'h10,8'h27,8'h45,8'h45,8'h45,8'h39,8'h3C,8'h4A,
        8'h49,8'h49,8'h30,8'h01,8'h71,8'h09,8'h05,8'h03,8'h36,8'h49,8'h49,8'h49,8'h36,8'h06,8'h49,8'h49,
        8'h29,8'h1E,8'h00,8'h36,8'h36,8'h00,8'h00,8'h00,8'h56,8'h36,8'h00,8'h00,8'h00,8'h08,8'h14,8'h22,
        8'h41,8'h14,8'h14,8'h14,8'h14,8'h14,8'h41,8'h22,8'h14,8'h08,8'h00,8'h02,8'h01,8'h51,8'h09,8'h06,
        8'h32,8'h49,8'h79,8'h41,8'h3E,8'h7E,8'h11,8'h11,8'h11,8'h7E,8'h7F,8'h49,8'h49,8'h49,8'h36,8'h3E,
        8'h41,8'h41,8'h41,8'h22,8'h7F,8'h41,8'h41,8'h22,8'h1C,8'h7F,8'h49,8'h49,8'h49,8'h41,8'h7F,8'h09,
        8'h09,8'h09,8'h01,8'h3E,8'h41,8'h41,8'h49,8'h7A,8'h7F,8'h08,8'h08,8'h08,8'h7F,8'h00,8'h41,8'h7F,
        8'h41,8'h00,8'h20,8'h40,8'h41,8'h3F,8'h01,8'h7F,8'h08,8'h14,8'h22,8'h41,8'h7F,8'h40,8'h40,8'h40,
        8'h40,8'h7F,8'h02,8'h04,8'h02,8'h7F,8'h7F,8'h04,8'h08,8'h10,8'h7F,8'h3E,8'h41,8'h41,8'h41,8'h3E,
        8'h7F,8'h09,8'h09,8'h09,8'h06,8'h3E,8'h41,8'h51,8'h21,8'h5E,8'h7F,8'h09,8'h19,8'h29,8'h46,8'h46,
        8'h49,8'h49,8'h49,8'h31,8'h01,8'h01,8'h7F,8'h01,8'h01,8'h3F,8'h40,8'h40,8'h40,8'h3F,8'h1F,8'h20,
        8'h40,8'h20,8'h1F,8'h7F,8'h20,8'h18,8'h20,8'h7F,8'h63,8'h14,8'h08,8'h14,8'h63,8'h03,8'h04,8'h78,
        8'h04,8'h03,8'h61,8'h51,8'h49,8'h45,8'h43,8'h00,8'h00,8'h7F,8'h41,8'h41,8'h02,8'h04,8'h08,8'h10,
        8'h20,8'h41,8'h41,8'h7F,8'h00,8'h00,8'h04,8'h02,8'h01,8'h02,8'h04,8'h40,8'h40,8'h40,8'h40,8'h40,
        8'h00,8'h01,8'h02,8'h04,8'h00,8'h20,8'h54,8'h54,8'h54,8'h78,8'h7F,8'h48,8'h44,8'h44,8'h38,8'h38,
        8'h44,8'h44,8'h44,8'h20,8'h38,8'h44,8'h44,8'h48,8'h7F,8'h38,8'h54,8'h54,8'h54,8'h18,8'h08,8'h7E,
        8'h09,8'h01,8'h02,8'h08,8'h14,8'h54,8'h54,8'h3C,8'h7F,8'h08,8'h04,8'h04,8'h78,8'h00,8'h44,8'h7D,
        8'h40,8'h00,8'h20,8'h40,8'h44,8'h3D,8'h00,8'h00,8'h7F,8'h10,8'h28,8'h44,8'h00,8'h41,8'h7F,8'h40,
        8'h00,8'h7C,8'h04,8'h18,8'h04,8'h78,8'h7C,8'h08,8'h04,8'h04,8'h78,8'h38,8'h44,8'h44,8'h44,8'h38,
        8'h7C,8'h14,8'h14,8'h14,8'h08,8'h08,8'h14,8'h14,8'h18,8'h7C,8'h7C,8'h08,8'h04,8'h04,8'h08,8'h48,
        8'h54,8'h54,8'h54,8'h20,8'h04,8'h3F,8'h44,8'h40,8'h20,8'h3C,8'h40,8'h40,8'h20,8'h7C,8'h1C,8'h20,
        8'h40,8'h20,8'h1C,8'h3C,8'h40,8'h30,8'h40,8'h3C,8'h44,8'h28,8'h10,8'h28,8'h44,8'h0C,8'h50,8'h50,
        8'h50,8'h3C,8'h44,8'h64,8'h54,8'h4C,8'h44,8'h00,8'h08,8'h36,8'h41,8'h00,8'h00,8'h00,8'h7F,8'h00,
        8'h00,8'h00,8'h41,8'h36,8'h08,8'h00,8'h08,8'h08,8'h2A,8'h1C,8'h08,8'h7F,8'h7F,8'h7F,8'h7F,8'h7F
    };

    typedef struct {
        logic [1:0]  command;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [15:0] rect_width;
        logic [15:0] rect_height;
        logic [7:0]  char_code;
        logic [15:0] fg_color;
        logic [15:0] bg_color;
        logic [1:0]  rotation;
        logic        rgb_order;
    } draw_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] value;
        logic [14:0] run_len;
        logic        last;
    } panel_result_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [111:0]                     s_axis_tdata = '0;
    logic [1:0]                       s_axis_tuser = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [31:0]                      m_axis_tdata;
    logic [1:0]                       m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             cfg_we = 1'b0;
    logic [lcddcg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                      cfg_data = '0;

    panel_result_t panel_results_due [$];
    logic [15:0]   column_shift = '0;
    logic [15:0]   row_shift = '0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            stall_left = 0;
    bit            sender_gaps = 1'b1;
    bit            receiver_stalls = 1'b1;

    lcd_draw_command_generator uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    // mostly no gap, sometimes a short one, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        else if (pick < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------
    function automatic void emit(input logic [1:0] kind, input logic [15:0] value,
                                 input logic [14:0] run_len);
        panel_result_t res;
        res.kind    = kind;
        res.value   = value;
        res.run_len = run_len;
        res.last    = 1'b0;
        panel_results_due.push_back(res);
    endfunction

    function automatic void emit_pair(input logic [15:0] v);
        emit(lcddcg_pkg::KIND_DATA, {8'h00, v[15:8]}, '0);
        emit(lcddcg_pkg::KIND_DATA, {8'h00, v[7:0]}, '0);
    endfunction

    function automatic void emit_window(input int x0, input int y0, input int x1, input int y1);
        emit(lcddcg_pkg::KIND_CMD, {8'h00, lcddcg_pkg::LCD_CASET}, '0);
        emit_pair(x0[15:0] + column_shift);
        emit_pair(x1[15:0] + column_shift);
        emit(lcddcg_pkg::KIND_CMD, {8'h00, lcddcg_pkg::LCD_RASET}, '0);
        emit_pair(y0[15:0] + row_shift);
        emit_pair(y1[15:0] + row_shift);
        emit(lcddcg_pkg::KIND_CMD, {8'h00, lcddcg_pkg::LCD_RAMWR}, '0);
    endfunction

    // pushes the expected sequence of one request, returns its length
    function automatic int predict_panel_sequence(input draw_req_t r);
        int          x0, y0, x1, y1, w, h, base, first;
        logic [7:0]  col_bits;
        logic [7:0]  mad;
        logic        lit;
        logic [14:0] pixels;
        first = panel_results_due.size();
        x0 = r.x_pos;
        y0 = r.y_pos;
        w  = r.rect_width;
        h  = r.rect_height;
        case (r.command)
            lcddcg_pkg::OP_FILL:
            begin
                if (w != 0 && h != 0 && x0 < lcddcg_pkg::SCREEN_WIDTH &&
                    y0 < lcddcg_pkg::SCREEN_HEIGHT)
                begin
                    x1 = x0 + w - 1;
                    y1 = y0 + h - 1;
                    if (x1 >= lcddcg_pkg::SCREEN_WIDTH)
                        x1 = lcddcg_pkg::SCREEN_WIDTH - 1;
                    if (y1 >= lcddcg_pkg::SCREEN_HEIGHT)
                        y1 = lcddcg_pkg::SCREEN_HEIGHT - 1;
                    emit_window(x0, y0, x1, y1);
                    pixels = 15'((x1 - x0 + 1) * (y1 - y0 + 1));
                    emit(lcddcg_pkg::KIND_RUN, r.fg_color, pixels);
                end
            end
            lcddcg_pkg::OP_CHAR:
            begin
                if (r.char_code >= lcddcg_pkg::FIRST_CODE &&
                    r.char_code <= lcddcg_pkg::FINAL_CODE &&
                    x0 + lcddcg_pkg::GLYPH_WIDTH <= lcddcg_pkg::SCREEN_WIDTH &&
                    y0 + lcddcg_pkg::GLYPH_HEIGHT <= lcddcg_pkg::SCREEN_HEIGHT)
                begin
                    base = (int'(r.char_code) - int'(lcddcg_pkg::FIRST_CODE)) * 5;
                    emit_window(x0, y0, x0 + lcddcg_pkg::GLYPH_WIDTH - 1,
                                y0 + lcddcg_pkg::GLYPH_HEIGHT - 1);
                    for (int row = 0; row < lcddcg_pkg::GLYPH_HEIGHT; row++)
                    begin
                        for (int col = 0; col < lcddcg_pkg::GLYPH_WIDTH; col++)
                        begin
                            col_bits = FONT_BYTES[(base + col) % 480];
                            // rows below the eighth have no font bit and show background
                            lit = (row < 8) ? col_bits[row[2:0]] : 1'b0;
                            emit(lcddcg_pkg::KIND_RUN, lit ? r.fg_color : r.bg_color, 15'd1);
                        end
                    end
                end
            end
            lcddcg_pkg::OP_ROT:
            begin
                case (r.rotation)
                    2'd0:    mad = 8'h00;
                    2'd1:    mad = lcddcg_pkg::MAD_ROT1;
                    2'd2:    mad = lcddcg_pkg::MAD_ROT2;
                    default: mad = lcddcg_pkg::MAD_ROT3;
                endcase
                if (!r.rgb_order)
                    mad = mad | lcddcg_pkg::MAD_BGR;
                emit(lcddcg_pkg::KIND_CMD, {8'h00, lcddcg_pkg::LCD_MADCTL}, '0);
                emit(lcddcg_pkg::KIND_DATA, {8'h00, mad}, '0);
            end
            default:
            begin
            end
        endcase
        if (panel_results_due.size() > first)
            panel_results_due[panel_results_due.size() - 1].last = 1'b1;
        return panel_results_due.size() - first;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input panel_result_t want,
                                 input panel_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s: exp kind=%0d value=%h run=%0d last=%b,", what,
                     want.kind, want.value, want.run_len, want.last,
                     " got kind=%0d value=%h run=%0d last=%b",
                     got.kind, got.value, got.run_len, got.last);
    endtask

    always @(posedge clk)
    begin
        panel_result_t got;
        panel_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind    = m_axis_tuser;
            got.value   = m_axis_tdata[15:0];
            got.run_len = m_axis_tdata[30:16];
            got.last    = m_axis_tlast;
            if (panel_results_due.size() == 0)
            begin
                note_mismatch("unexpected result", '0, got);
            end
            else
            begin
                want = panel_results_due.pop_front();
                if (got.kind !== want.kind || got.value !== want.value ||
                    got.run_len !== want.run_len || got.last !== want.last)
                    note_mismatch("wrong result", want, got);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("lcd_draw_command_generator: mismatch");
            $finish;
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left <= receiver_stalls ? idle_len() : 0;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic draw_req_t make_req(input logic [1:0] command, input int x, input int y,
                                           input int w, input int h, input logic [7:0] code,
                                           input logic [15:0] fg, input logic [15:0] bg,
                                           input logic [1:0] rot, input logic rgb);
        draw_req_t r;
        r.command     = command;
        r.x_pos       = x[15:0];
        r.y_pos       = y[15:0];
        r.rect_width  = w[15:0];
        r.rect_height = h[15:0];
        r.char_code   = code;
        r.fg_color    = fg;
        r.bg_color    = bg;
        r.rotation    = rot;
        r.rgb_order   = rgb;
        return r;
    endfunction

    // tvalid stays high after the request so a zero gap gives back-to-back requests
    task automatic send_request(input draw_req_t r, output int produced);
        int gap;
        gap = sender_gaps ? idle_len() : 0;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.command;
        s_axis_tdata  <= {5'b0, r.rgb_order, r.rotation, r.bg_color, r.fg_color, r.char_code,
                          r.rect_height, r.rect_width, r.y_pos, r.x_pos};
        do
            @(posedge clk);
        while (!s_axis_tready);
        produced = predict_panel_sequence(r);
    endtask

    task automatic send(input draw_req_t r);
        int produced;
        send_request(r, produced);
    endtask

    // stop sending and let every expected result and any dropped request clear
    task automatic settle_outputs();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (panel_results_due.size() != 0)
            @(posedge clk);
        repeat (QUIET_WAIT) @(posedge clk);
    endtask

    task automatic set_register(input logic [lcddcg_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == lcddcg_pkg::REG_COLUMN_OFFSET)
            column_shift = v;
        else
            row_shift = v;
    endtask

    function automatic draw_req_t random_request();
        draw_req_t r;
        int        pick;
        r = make_req(2'($urandom_range(0, 2)), $urandom, $urandom, $urandom, $urandom,
                     8'($urandom), 16'($urandom), 16'($urandom), 2'($urandom), 1'($urandom));
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            // raw noise over every field, unused command included
            r.command = 2'($urandom_range(0, 3));
            return r;
        end
        case (r.command)
            lcddcg_pkg::OP_FILL:
            begin
                r.x_pos = 16'($urandom_range(0, lcddcg_pkg::SCREEN_WIDTH - 1));
                r.y_pos = 16'($urandom_range(0, lcddcg_pkg::SCREEN_HEIGHT - 1));
                if ($urandom_range(0, 3) != 0)
                begin
                    r.rect_width  = 16'($urandom_range(1, 40));
                    r.rect_height = 16'($urandom_range(1, 40));
                end
                if (pick < 18)
                begin
                    case ($urandom_range(0, 3))
                        0:       r.rect_width  = '0;
                        1:       r.rect_height = '0;
                        2:       r.x_pos = 16'($urandom_range(lcddcg_pkg::SCREEN_WIDTH, 65535));
                        default: r.y_pos = 16'($urandom_range(lcddcg_pkg::SCREEN_HEIGHT, 65535));
                    endcase
                end
            end
            lcddcg_pkg::OP_CHAR:
            begin
                r.char_code = 8'($urandom_range(lcddcg_pkg::FIRST_CODE, lcddcg_pkg::FINAL_CODE));
                r.x_pos = 16'($urandom_range(0, lcddcg_pkg::SCREEN_WIDTH -
                                                lcddcg_pkg::GLYPH_WIDTH));
                r.y_pos = 16'($urandom_range(0, lcddcg_pkg::SCREEN_HEIGHT -
                                                lcddcg_pkg::GLYPH_HEIGHT));
                if (pick < 18)
                begin
                    case ($urandom_range(0, 2))
                        0:       r.char_code = 8'($urandom_range(0, 8'hFF) & 8'h9F);
                        1:       r.x_pos = 16'($urandom_range(lcddcg_pkg::SCREEN_WIDTH -
                                                              lcddcg_pkg::GLYPH_WIDTH + 1,
                                                              65535));
                        default: r.y_pos = 16'($urandom_range(lcddcg_pkg::SCREEN_HEIGHT -
                                                              lcddcg_pkg::GLYPH_HEIGHT + 1,
                                                              65535));
                    endcase
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_rotation();
        for (int rot = 0; rot < 4; rot++)
            send(make_req(lcddcg_pkg::OP_ROT, 0, 0, 0, 0, 8'h00, 16'h0000, 16'h0000,
                          rot[1:0], rot[0]));
    endtask

    task automatic test_fill_shapes();
        send(make_req(lcddcg_pkg::OP_FILL, 0, 0, lcddcg_pkg::SCREEN_WIDTH,
                      lcddcg_pkg::SCREEN_HEIGHT, 8'h00, 16'hFFFF, 16'h0000, 2'd0, 1'b1));
        // single pixel in the far corner
        send(make_req(lcddcg_pkg::OP_FILL, lcddcg_pkg::SCREEN_WIDTH - 1,
                      lcddcg_pkg::SCREEN_HEIGHT - 1, 1, 1, 8'h00, 16'h0000, 16'hFFFF,
                      2'd0, 1'b0));
        // far corner clipped to the screen
        send(make_req(lcddcg_pkg::OP_FILL, 150, 120, 65535, 65535, 8'h00, 16'hA5A5, 16'h5A5A,
                      2'd3, 1'b1));
        send(make_req(lcddcg_pkg::OP_FILL, 0, 0, 1, 1, 8'h00, 16'h5A5A, 16'hA5A5, 2'd0, 1'b0));
    endtask

    task automatic test_dropped_requests();
        send(make_req(lcddcg_pkg::OP_FILL, 10, 10, 0, 5, 8'h00, 16'h1234, 16'h0000,
                      2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_FILL, 10, 10, 5, 0, 8'h00, 16'h1234, 16'h0000,
                      2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_FILL, lcddcg_pkg::SCREEN_WIDTH, 0, 5, 5, 8'h00, 16'h1234,
                      16'h0000, 2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_FILL, 0, lcddcg_pkg::SCREEN_HEIGHT, 5, 5, 8'h00, 16'h1234,
                      16'h0000, 2'd0, 1'b0));
        send(make_req(OP_UNUSED, 3, 3, 3, 3, 8'h41, 16'hFFFF, 16'hFFFF, 2'd3, 1'b1));
    endtask

    task automatic test_glyphs();
        send(make_req(lcddcg_pkg::OP_CHAR, 0, 0, 0, 0, lcddcg_pkg::FIRST_CODE, 16'hFFFF,
                      16'h0000, 2'd0, 1'b0));
        // glyph touching the right and bottom edges exactly
        send(make_req(lcddcg_pkg::OP_CHAR, lcddcg_pkg::SCREEN_WIDTH - lcddcg_pkg::GLYPH_WIDTH,
                      lcddcg_pkg::SCREEN_HEIGHT - lcddcg_pkg::GLYPH_HEIGHT, 0, 0,
                      lcddcg_pkg::FINAL_CODE, 16'h0000, 16'hFFFF, 2'd0, 1'b1));
        send(make_req(lcddcg_pkg::OP_CHAR, 40, 30, 0, 0, 8'h41, 16'hF800, 16'h001F,
                      2'd1, 1'b0));
        send(make_req(lcddcg_pkg::OP_CHAR, 40, 30, 0, 0, lcddcg_pkg::FIRST_CODE - 8'd1,
                      16'hF800, 16'h001F, 2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_CHAR, 40, 30, 0, 0, lcddcg_pkg::FINAL_CODE + 8'd1,
                      16'hF800, 16'h001F, 2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_CHAR, 40, 30, 0, 0, 8'hFF, 16'hF800, 16'h001F,
                      2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_CHAR, lcddcg_pkg::SCREEN_WIDTH - lcddcg_pkg::GLYPH_WIDTH + 1,
                      0, 0, 0, 8'h41, 16'h07E0, 16'h0000, 2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_CHAR, 0,
                      lcddcg_pkg::SCREEN_HEIGHT - lcddcg_pkg::GLYPH_HEIGHT + 1, 0, 0, 8'h41,
                      16'h07E0, 16'h0000, 2'd0, 1'b0));
    endtask

    task automatic test_offset_wrap();
        settle_outputs();
        set_register(lcddcg_pkg::REG_COLUMN_OFFSET, 16'hFFFF);
        set_register(lcddcg_pkg::REG_ROW_OFFSET, 16'hFFFF);
        send(make_req(lcddcg_pkg::OP_FILL, lcddcg_pkg::SCREEN_WIDTH - 1,
                      lcddcg_pkg::SCREEN_HEIGHT - 1, 9, 9, 8'h00, 16'h0F0F, 16'h0000,
                      2'd0, 1'b0));
        send(make_req(lcddcg_pkg::OP_CHAR, 0, 0, 0, 0, 8'h7E, 16'hFFFF, 16'h0000, 2'd0, 1'b0));
    endtask

    task automatic test_random_traffic();
        int drawn;
        int produced;
        for (int phase = 0; phase < 5; phase++)
        begin
            settle_outputs();
            case (phase)
                0:
                begin
                    set_register(lcddcg_pkg::REG_COLUMN_OFFSET, 16'hFFFF);
                    set_register(lcddcg_pkg::REG_ROW_OFFSET, 16'h0000);
                    sender_gaps = 1'b1;
                    receiver_stalls = 1'b1;
                end
                1:
                begin
                    set_register(lcddcg_pkg::REG_COLUMN_OFFSET, 16'($urandom));
                    set_register(lcddcg_pkg::REG_ROW_OFFSET, 16'($urandom));
                    sender_gaps = 1'b0;
                    receiver_stalls = 1'b0;
                end
                2:
                begin
                    set_register(lcddcg_pkg::REG_COLUMN_OFFSET, 16'h0000);
                    set_register(lcddcg_pkg::REG_ROW_OFFSET, 16'hFFFF);
                    sender_gaps = 1'b1;
                    receiver_stalls = 1'b0;
                end
                3:
                begin
                    set_register(lcddcg_pkg::REG_COLUMN_OFFSET, 16'($urandom));
                    set_register(lcddcg_pkg::REG_ROW_OFFSET, 16'($urandom));
                    sender_gaps = 1'b0;
                    receiver_stalls = 1'b1;
                end
                default:
                begin
                    set_register(lcddcg_pkg::REG_COLUMN_OFFSET, 16'h0000);
                    set_register(lcddcg_pkg::REG_ROW_OFFSET, 16'h0000);
                    sender_gaps = 1'b1;
                    receiver_stalls = 1'b1;
                end
            endcase
            drawn = 0;
            // dropped requests do not count towards the phase
            while (drawn < PHASE_DRAWS)
            begin
                send_request(random_request(), produced);
                if (produced != 0)
                    drawn++;
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_rotation();
        test_fill_shapes();
        test_dropped_requests();
        test_glyphs();
        test_offset_wrap();
        test_random_traffic();
        settle_outputs();

        if (mismatch_count == 0)
            $display("lcd_draw_command_generator: match");
        else
            $display("lcd_draw_command_generator: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/lcddcg_pkg.sv
design/lcddcg_front.sv
design/lcddcg_queue.sv
design/lcddcg_back.sv
design/lcd_draw_command_generator.sv
dv/tb_lcd_draw_command_generator.sv
